[hw/rtl/cca_pkg.sv]
// cca_pkg: shared types, codes and constants of the cone colour association engine
// no dependencies; imported by every module of the block

package cca_pkg;

  localparam int SHORT_DEPTH_DEF = 64;
  localparam int LONG_DEPTH_DEF  = 256;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int DIST_OUT_W = 33;
  localparam int CFG_IDX_W  = 2;

  // item function codes
  localparam logic [2:0] FN_ADD_BLUE   = 3'd0;
  localparam logic [2:0] FN_ADD_YELLOW = 3'd1;
  localparam logic [2:0] FN_SHIFT      = 3'd2;
  localparam logic [2:0] FN_CLASSIFY   = 3'd3;
  localparam logic [2:0] FN_FRAME_END  = 3'd4;

  // result classes
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_YELLOW = 2'd1;
  localparam logic [1:0] CLS_BLUE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE = 2'd1;

  localparam logic [31:0] THRESH_RESET  = 32'd16384;
  localparam logic [7:0]  MAX_AGE_RESET = 8'd10;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
  } cca_in_t;

  typedef struct packed {
    logic [1:0]            cls_code;
    logic                  from_long_term;
    logic [DIST_OUT_W-1:0] best_dist_sq;
  } cca_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SWEEP,
    ST_DRAIN,
    ST_CHECK,
    ST_RESULT
  } cca_state_t;

  typedef struct packed {
    logic load_item;
    logic add_en;
    logic sweep_start;
    logic sweep_long;
    logic sweep_step;
    logic age_commit;
    logic load_out;
  } cca_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
    logic hit;
    logic out_busy;
  } cca_stat_t;

endpackage

[hw/rtl/cca_ctrl.sv]
// cca_ctrl: sequencing state machine of the cone colour association engine
// depends on cca_pkg; drives the datapath through cca_cmd_t, reads cca_stat_t

module cca_ctrl import cca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  cca_stat_t  stat,
  output cca_cmd_t   cmd
);

  cca_state_t state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  logic       long_r, long_nxt;
  logic       is_sweep_fn;

  always_comb begin
    case (in_func) inside
      FN_SHIFT, FN_CLASSIFY, FN_FRAME_END: is_sweep_fn = 1'b1;
      default:                             is_sweep_fn = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      func_r  <= FN_ADD_BLUE;
      long_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      func_r  <= func_nxt;
      long_r  <= long_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    long_nxt  = long_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          long_nxt = 1'b0;
          case (in_func) inside
            FN_ADD_BLUE, FN_ADD_YELLOW: state_nxt = ST_ADD;
            FN_SHIFT, FN_CLASSIFY, FN_FRAME_END: state_nxt = ST_SWEEP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: state_nxt = ST_IDLE;
      ST_SWEEP: begin
        if (stat.issue_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) state_nxt = (func_r == FN_CLASSIFY) ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (stat.hit || long_r) begin
          state_nxt = ST_RESULT;
        end else begin
          // short-term stores undecided, fall back to the long-term rings
          long_nxt  = 1'b1;
          state_nxt = ST_SWEEP;
        end
      end
      ST_RESULT: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall        = 1'b0;
        cmd.load_item   = in_valid;
        cmd.sweep_start = in_valid && is_sweep_fn;
      end
      ST_ADD: cmd.add_en = 1'b1;
      ST_SWEEP: cmd.sweep_step = !stat.issue_done;
      ST_DRAIN: cmd.age_commit = stat.pipe_empty && (func_r == FN_FRAME_END);
      ST_CHECK: begin
        cmd.sweep_start = !(stat.hit || long_r);
        cmd.sweep_long  = !(stat.hit || long_r);
      end
      ST_RESULT: cmd.load_out = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/cca_dp.sv]
// cca_dp: stores, sweep pipeline, nearest-distance search and result register
// depends on cca_pkg; commanded by cca_ctrl

module cca_dp import cca_pkg::*; #(
  parameter int SHORT_DEPTH = SHORT_DEPTH_DEF,
  parameter int LONG_DEPTH  = LONG_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cca_in_t              in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  cca_cmd_t             cmd,
  output cca_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cca_out_t             out_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int SW   = $clog2(SHORT_DEPTH);
  localparam int SCW  = $clog2(SHORT_DEPTH + 1);
  localparam int LW   = $clog2(LONG_DEPTH);
  localparam int LCW  = $clog2(LONG_DEPTH + 1);
  localparam int MAXD = (SHORT_DEPTH > LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH;
  localparam int IW   = $clog2(MAXD + 1);
  localparam int EW   = ((CW > 16) ? CW : 16) + 2;
  localparam int DW   = 2 * CW + 2;
  localparam int MW   = (DW > 32) ? DW : 32;
  localparam int SMW  = 2 * CW + 8;
  localparam int LMW  = 2 * CW;

  localparam logic signed [EW-1:0] CMAX = EW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] CMIN = EW'(-(64'sd1 <<< (CW - 1)));
  localparam logic [SCW-1:0] SFULL = SCW'(SHORT_DEPTH);
  localparam logic [LCW-1:0] LFULL = LCW'(LONG_DEPTH);
  localparam logic [LW-1:0]  LLAST = LW'(LONG_DEPTH - 1);

  function automatic logic signed [CW-1:0] sat_c(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > CMAX)      r = CMAX[CW-1:0];
    else if (v < CMIN) r = CMIN[CW-1:0];
    else               r = v[CW-1:0];
    return r;
  endfunction

  // ring position: base plus offset, modulo the short depth
  function automatic logic [SW-1:0] wrap_s(input logic [SW-1:0] b, input logic [SW-1:0] o);
    logic [SW:0] s;
    s = {1'b0, b} + {1'b0, o};
    if (s >= (SW + 1)'(SHORT_DEPTH)) s = s - (SW + 1)'(SHORT_DEPTH);
    return s[SW-1:0];
  endfunction

  logic [31:0] thresh_r;
  logic [7:0]  max_age_r;

  logic [2:0]           func_r;
  logic signed [CW-1:0] px_r, py_r;
  logic signed [15:0]   sx_r, sy_r;

  logic [IW-1:0] idx_r;
  logic          long_r;

  logic [IW-1:0] lim [2];
  logic [DW-1:0] min_v [2];
  logic          found_v [2];
  logic          empty_v [2];
  logic [IW-1:0] lim_max;

  logic     out_valid_r;
  cca_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RESET;
      max_age_r <= MAX_AGE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESH:  thresh_r  <= cfg_data;
        REG_MAX_AGE: max_age_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_data.func;
      px_r   <= sat_c(EW'(in_data.pos_x));
      py_r   <= sat_c(EW'(in_data.pos_y));
      sx_r   <= in_data.shift_x;
      sy_r   <= in_data.shift_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      long_r <= 1'b0;
    end else if (cmd.sweep_start) begin
      idx_r  <= '0;
      long_r <= cmd.sweep_long;
    end else if (cmd.sweep_step) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  assign lim_max = (lim[0] > lim[1]) ? lim[0] : lim[1];

  for (genvar c = 0; c < 2; c++) begin : g_col
    localparam logic [2:0] ADD_FN = (c == 0) ? FN_ADD_BLUE : FN_ADD_YELLOW;

    logic [SMW-1:0] smem [SHORT_DEPTH];
    logic [LMW-1:0] lmem [LONG_DEPTH];
    logic [SMW-1:0] s_rd_r;
    logic [LMW-1:0] l_rd_r;

    logic [SW-1:0]  head_r;
    logic [SCW-1:0] cnt_r;
    logic [SCW-1:0] k_r;
    logic [LW-1:0]  lptr_r;
    logic [LCW-1:0] lcnt_r;

    logic v1_r, v2_r, v3_r;
    logic [SW-1:0]          addr1_r;
    logic signed [CW:0]     dx_r, dy_r;
    logic [DW-1:0]          sqx_r, sqy_r;
    logic [DW-1:0]          min_r;
    logic                   found_r;

    logic                   add_hit, iss, keep;
    logic [SW-1:0]          s_raddr, s_wa;
    logic [SMW-1:0]         s_wd;
    logic                   s_we;
    logic signed [CW-1:0]   rx, ry;
    logic [7:0]             age;
    logic signed [2*CW+1:0] dxe, dye;
    logic [DW-1:0]          dsum;

    assign add_hit = cmd.add_en && (func_r == ADD_FN);
    assign lim[c]  = long_r ? IW'(lcnt_r) : IW'(cnt_r);
    assign iss     = cmd.sweep_step && (idx_r < lim[c]);
    assign s_raddr = wrap_s(head_r, idx_r[SW-1:0]);

    assign rx   = long_r ? l_rd_r[CW-1:0]      : s_rd_r[CW-1:0];
    assign ry   = long_r ? l_rd_r[2*CW-1:CW]   : s_rd_r[2*CW-1:CW];
    assign age  = s_rd_r[SMW-1:2*CW];
    assign keep = age < max_age_r;

    always_comb begin
      s_we = 1'b0;
      s_wa = addr1_r;
      s_wd = {age, ry, rx};
      if (add_hit) begin
        s_we = 1'b1;
        s_wa = (cnt_r == SFULL) ? head_r : wrap_s(head_r, cnt_r[SW-1:0]);
        s_wd = {8'd0, py_r, px_r};
      end else if (v1_r && !long_r && func_r == FN_SHIFT) begin
        s_we = 1'b1;
        s_wd = {age, sat_c(EW'(ry) - EW'(sy_r)), sat_c(EW'(rx) - EW'(sx_r))};
      end else if (v1_r && !long_r && func_r == FN_FRAME_END && keep) begin
        // survivors are packed down towards the head in order
        s_we = 1'b1;
        s_wa = wrap_s(head_r, k_r[SW-1:0]);
        s_wd = {age + 8'd1, ry, rx};
      end
    end

    always_ff @(posedge clk) begin
      if (s_we) smem[s_wa] <= s_wd;
      s_rd_r <= smem[s_raddr];
    end

    always_ff @(posedge clk) begin
      if (add_hit && thresh_r != 32'd0) lmem[lptr_r] <= {py_r, px_r};
      l_rd_r <= lmem[idx_r[LW-1:0]];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r <= '0;
        cnt_r  <= '0;
        lptr_r <= '0;
        lcnt_r <= '0;
        v1_r   <= 1'b0;
        v2_r   <= 1'b0;
        v3_r   <= 1'b0;
      end else begin
        v1_r <= iss;
        v2_r <= v1_r && (func_r == FN_CLASSIFY);
        v3_r <= v2_r;
        if (add_hit) begin
          if (cnt_r == SFULL) head_r <= wrap_s(head_r, SW'(1));
          else                cnt_r  <= cnt_r + SCW'(1);
          if (thresh_r != 32'd0) begin
            lptr_r <= (lptr_r == LLAST) ? '0 : lptr_r + LW'(1);
            if (lcnt_r != LFULL) lcnt_r <= lcnt_r + LCW'(1);
          end
        end
        if (cmd.age_commit) cnt_r <= k_r;
      end
    end

    assign dxe  = (2 * CW + 2)'(dx_r);
    assign dye  = (2 * CW + 2)'(dy_r);
    assign dsum = sqx_r + sqy_r;

    always_ff @(posedge clk) begin
      addr1_r <= s_raddr;
      dx_r    <= (CW + 1)'(rx) - (CW + 1)'(px_r);
      dy_r    <= (CW + 1)'(ry) - (CW + 1)'(py_r);
      sqx_r   <= DW'(dxe * dxe);
      sqy_r   <= DW'(dye * dye);
      if (cmd.sweep_start) begin
        k_r     <= '0;
        found_r <= 1'b0;
      end else begin
        if (v1_r && !long_r && func_r == FN_FRAME_END && keep) k_r <= k_r + SCW'(1);
        if (v3_r && (!found_r || dsum < min_r)) begin
          min_r   <= dsum;
          found_r <= 1'b1;
        end
      end
    end

    assign min_v[c]   = min_r;
    assign found_v[c] = found_r;
    assign empty_v[c] = !(v1_r || v2_r || v3_r);
  end

  // colour decision: strictly closer colour, strictly under threshold
  logic       b_win, y_win;
  logic [1:0] cls;
  logic [DW-1:0] win;

  assign b_win = found_v[0] && (!found_v[1] || min_v[0] < min_v[1]) &&
                 (MW'(min_v[0]) < MW'(thresh_r));
  assign y_win = found_v[1] && (!found_v[0] || min_v[1] < min_v[0]) &&
                 (MW'(min_v[1]) < MW'(thresh_r));
  assign cls   = b_win ? CLS_BLUE : (y_win ? CLS_YELLOW : CLS_NONE);
  assign win   = b_win ? min_v[0] : min_v[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.cls_code       <= cls;
      out_data_r.from_long_term <= long_r && (cls != CLS_NONE);
      out_data_r.best_dist_sq   <= (cls != CLS_NONE) ? DIST_OUT_W'(win) : '1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.issue_done = idx_r >= lim_max;
  assign stat.pipe_empty = empty_v[0] && empty_v[1];
  assign stat.hit        = cls != CLS_NONE;
  assign stat.out_busy   = out_valid_r && out_stall;

endmodule

[hw/rtl/cone_color_association_engine.sv]
// Cone colour association engine. Items are taken one at a time. Shift and
// frame end sweep both short-term histories together, one entry a cycle.
// Classify scans the short-term histories the same way and, when they leave
// the cone undecided, the long-term rings, then loads the result. Each store
// has a single read port. A result waits in an output register and the next
// item is taken while it waits. No clearing pass is needed after reset. The
// configuration port is always ready and must be written only while idle.
// Depends on cca_pkg, cca_ctrl and cca_dp.

module cone_color_association_engine import cca_pkg::*; #(
  parameter int SHORT_DEPTH = SHORT_DEPTH_DEF,
  parameter int LONG_DEPTH  = LONG_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cca_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cca_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cca_cmd_t  cmd;
  cca_stat_t stat;

  assign cfg_ready = 1'b1;

  cca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_data.func),
    .stat     (stat),
    .cmd      (cmd)
  );

  cca_dp #(
    .SHORT_DEPTH (SHORT_DEPTH),
    .LONG_DEPTH  (LONG_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/cca_checker.sv]
// cca_props: port-level checks of the cone colour association engine
// depends on cca_pkg; bound to the top level at the end of this file

module cca_props import cca_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input cca_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cls_code == CLS_NONE || out_data.cls_code == CLS_YELLOW ||
                   out_data.cls_code == CLS_BLUE))
    else $error("invalid class code");

  a_unclassified: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cls_code == CLS_NONE |->
      !out_data.from_long_term && out_data.best_dist_sq == '1)
    else $error("unclassified result not saturated");

  // a winning distance is under a 32-bit threshold
  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cls_code != CLS_NONE |-> !out_data.best_dist_sq[32])
    else $error("winning distance out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind cone_color_association_engine cca_props u_cca_props (.*);
